FILE: rtl/fpa_pkg.sv
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int REM_W     = DATA_W + 1;
    localparam int PROD_W    = 2 * DATA_W;

    typedef enum logic [3:0] {
        CMD_ADD    = 4'd0,
        CMD_SUB    = 4'd1,
        CMD_MUL    = 4'd2,
        CMD_DIV    = 4'd3,
        CMD_GT     = 4'd4,
        CMD_LT     = 4'd5,
        CMD_GE     = 4'd6,
        CMD_LE     = 4'd7,
        CMD_EQ     = 4'd8,
        CMD_NE     = 4'd9,
        CMD_INC    = 4'd10,
        CMD_DEC    = 4'd11,
        CMD_MAX    = 4'd12,
        CMD_TO_INT = 4'd13
    } t_cmd;

    // One item as it moves down the divider chain
    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic              neg;
        logic              derr;
        logic              flag;
        logic [DATA_W-1:0] res;
        logic [NUM_W-1:0]  nq;
        logic [REM_W-1:0]  rem;
        logic [DATA_W-1:0] den;
    } t_item;

endpackage

FILE: rtl/fixed_point_alu.sv
// Signed 32-bit fixed-point ALU, FRAC_BITS fraction bits.
// Input channel: i_valid / o_stall with i_cmd, i_a_operand, i_b_operand.
// Output channel: o_valid / i_stall with o_result, o_compare_flag,
// o_divide_error. A transfer happens on a clock edge with valid high and
// stall low.
// Every item, whatever its opcode, takes the same path: an operand
// register, a decode and multiply stage, a product scaling stage, one
// restoring divider step per quotient bit (32 + FRAC_BITS stages) and an
// output register. Results leave in input order. Throughput is one item
// per cycle unless the output stalls; the divider chain sets the depth.
// The whole pipeline advances together. While a result waits at the
// output under i_stall, every stage holds and o_stall is raised; nothing
// is dropped or repeated, and bubbles keep their places.
// Reset (i_rst_n low, synchronous) clears all valid bits.
module fixed_point_alu (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [3:0]                  i_cmd,
    input  logic [fpa_pkg::DATA_W-1:0]  i_a_operand,
    input  logic [fpa_pkg::DATA_W-1:0]  i_b_operand,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [fpa_pkg::DATA_W-1:0]  o_result,
    output logic                        o_compare_flag,
    output logic                        o_divide_error
);
    import fpa_pkg::*;

    logic  en;
    t_item chain [0:NUM_W];

    // Advance unless a result is held at the output
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    fpa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_valid),
        .i_cmd       (i_cmd),
        .i_a_operand (i_a_operand),
        .i_b_operand (i_b_operand),
        .o_item      (chain[0])
    );

    for (genvar k = 0; k < NUM_W; k++) begin : g_div
        fpa_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_item  (chain[k]),
            .o_item  (chain[k+1])
        );
    end

    fpa_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_item         (chain[NUM_W]),
        .o_valid        (o_valid),
        .o_result       (o_result),
        .o_compare_flag (o_compare_flag),
        .o_divide_error (o_divide_error)
    );

endmodule

FILE: rtl/fpa_front.sv
module fpa_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [3:0]                   i_cmd,
    input  logic [fpa_pkg::DATA_W-1:0]   i_a_operand,
    input  logic [fpa_pkg::DATA_W-1:0]   i_b_operand,
    output fpa_pkg::t_item               o_item
);
    import fpa_pkg::*;

    logic                     r_vld_a;
    t_cmd                     r_cmd;
    logic signed [DATA_W-1:0] r_a;
    logic signed [DATA_W-1:0] r_b;

    t_item                    r_item_b;
    t_item                    n_item_b;
    logic                     r_mul_b;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;

    t_item                    r_item_c;
    t_item                    n_item_c;

    logic signed [NUM_W-1:0]  num;
    logic                     a_ge_b;

    // Register the operands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_valid;
            r_cmd   <= t_cmd'(i_cmd);
            r_a     <= i_a_operand;
            r_b     <= i_b_operand;
        end
    end

    // Decode, simple results, multiply and divider setup
    always_comb begin
        num    = {r_a, {FRAC_BITS{1'b0}}};
        a_ge_b = (r_a >= r_b);
        n_prod = PROD_W'(r_a) * PROD_W'(r_b);
        n_item_b        = '0;
        n_item_b.valid  = r_vld_a;
        n_item_b.neg    = r_a[DATA_W-1] ^ r_b[DATA_W-1];
        n_item_b.nq     = r_a[DATA_W-1] ? NUM_W'(-num) : NUM_W'(num);
        n_item_b.den    = r_b[DATA_W-1] ? DATA_W'(-r_b) : DATA_W'(r_b);
        case (r_cmd)
            CMD_ADD:    n_item_b.res = DATA_W'(r_a + r_b);
            CMD_SUB:    n_item_b.res = DATA_W'(r_a - r_b);
            CMD_DIV: begin
                n_item_b.is_div = 1'b1;
                n_item_b.derr   = (r_b == '0);
            end
            CMD_GT:     n_item_b.flag = (r_a > r_b);
            CMD_LT:     n_item_b.flag = (r_a < r_b);
            CMD_GE:     n_item_b.flag = a_ge_b;
            CMD_LE:     n_item_b.flag = (r_a <= r_b);
            CMD_EQ:     n_item_b.flag = (r_a == r_b);
            CMD_NE:     n_item_b.flag = (r_a != r_b);
            CMD_INC:    n_item_b.res = DATA_W'(r_a + 1);
            CMD_DEC:    n_item_b.res = DATA_W'(r_a - 1);
            CMD_MAX:    n_item_b.res = a_ge_b ? r_a : r_b;
            CMD_TO_INT: n_item_b.res = DATA_W'(r_a >>> FRAC_BITS);
            default:    n_item_b.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_b.valid <= 1'b0;
        end else if (i_en) begin
            r_item_b <= n_item_b;
            r_mul_b  <= (r_cmd == CMD_MUL);
            r_prod   <= n_prod;
        end
    end

    // Scale the product back to fixed point
    always_comb begin
        n_item_c = r_item_b;
        if (r_mul_b) begin
            n_item_c.res = r_prod[FRAC_BITS +: DATA_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_c.valid <= 1'b0;
        end else if (i_en) begin
            r_item_c <= n_item_c;
        end
    end

    assign o_item = r_item_c;

endmodule

FILE: rtl/fpa_div_stage.sv
module fpa_div_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  fpa_pkg::t_item  i_item,
    output fpa_pkg::t_item  o_item
);
    import fpa_pkg::*;

    t_item            r_item;
    t_item            n_item;
    logic [REM_W-1:0] trial;
    logic             q_bit;

    // One restoring step: shift in a numerator bit, subtract if it fits
    always_comb begin
        trial = {i_item.rem[REM_W-2:0], i_item.nq[NUM_W-1]};
        q_bit = (trial >= {1'b0, i_item.den});
        n_item     = i_item;
        n_item.rem = q_bit ? REM_W'(trial - {1'b0, i_item.den}) : trial;
        n_item.nq  = {i_item.nq[NUM_W-2:0], q_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

FILE: rtl/fpa_back.sv
module fpa_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  fpa_pkg::t_item              i_item,
    output logic                        o_valid,
    output logic [fpa_pkg::DATA_W-1:0]  o_result,
    output logic                        o_compare_flag,
    output logic                        o_divide_error
);
    import fpa_pkg::*;

    logic              r_valid;
    logic [DATA_W-1:0] r_result;
    logic              r_flag;
    logic              r_derr;
    logic [DATA_W-1:0] n_result;
    logic [DATA_W-1:0] q_low;

    // Apply the quotient sign and pick the final value
    always_comb begin
        q_low = i_item.nq[DATA_W-1:0];
        if (!i_item.is_div) begin
            n_result = i_item.res;
        end else if (i_item.derr) begin
            n_result = '0;
        end else begin
            n_result = i_item.neg ? DATA_W'(-q_low) : q_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid  <= i_item.valid;
            r_result <= n_result;
            r_flag   <= i_item.flag;
            r_derr   <= i_item.derr;
        end
    end

    assign o_valid        = r_valid;
    assign o_result       = r_result;
    assign o_compare_flag = r_flag;
    assign o_divide_error = r_derr;

endmodule

FILE: rtl/fpa_checker.sv
module fpa_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_stall,
    input  logic                        o_valid,
    input  logic                        i_stall,
    input  logic [fpa_pkg::DATA_W-1:0]  o_result,
    input  logic                        o_compare_flag,
    input  logic                        o_divide_error
);
    import fpa_pkg::*;

    // Input side stalls only while a result is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // A comparison outcome carries a zero result
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_compare_flag) |-> (o_result == '0))
        else $error("compare flag with nonzero result");

    // Divide error gives zero and no compare flag
    a_derr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_error) |-> (o_result == '0 && !o_compare_flag))
        else $error("divide error with bad payload");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result)))
        else $error("stalled result changed");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_result       (o_result),
    .o_compare_flag (o_compare_flag),
    .o_divide_error (o_divide_error)
);

FILE: tb/sv/fixed_point_alu_checker.sv
module fixed_point_alu_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        o_stall,
    input  logic [3:0]                  i_cmd,
    input  logic [fpa_pkg::DATA_W-1:0]  i_a_operand,
    input  logic [fpa_pkg::DATA_W-1:0]  i_b_operand,
    input  logic                        o_valid,
    input  logic                        i_stall,
    input  logic [fpa_pkg::DATA_W-1:0]  o_result,
    input  logic                        o_compare_flag,
    input  logic                        o_divide_error,
    output int                          fail_count,
    output int                          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import fpa_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              compare_flag;
        logic              divide_error;
    } t_alu_out;

    t_alu_out expected_results[$];

    // Compute the result one operation gives
    function automatic t_alu_out alu_predict(logic [3:0] cmd, logic signed [31:0] a,
                                             logic signed [31:0] b);
        t_alu_out          r;
        logic signed [63:0] wide;
        logic signed [63:0] num;
        r = '0;
        case (cmd)
            CMD_ADD: r.result = a + b;
            CMD_SUB: r.result = a - b;
            CMD_MUL: begin
                wide = 64'(a) * 64'(b);
                wide = wide >>> FRAC_BITS;
                r.result = wide[31:0];
            end
            CMD_DIV: begin
                if (b == 0) begin
                    r.divide_error = 1'b1;
                end else begin
                    num = 64'(a) <<< FRAC_BITS;
                    wide = num / 64'(b);
                    r.result = wide[31:0];
                end
            end
            CMD_GT: r.compare_flag = a > b;
            CMD_LT: r.compare_flag = a < b;
            CMD_GE: r.compare_flag = a >= b;
            CMD_LE: r.compare_flag = a <= b;
            CMD_EQ: r.compare_flag = a == b;
            CMD_NE: r.compare_flag = a != b;
            CMD_INC: r.result = a + 1;
            CMD_DEC: r.result = a - 1;
            CMD_MAX: r.result = (a >= b) ? a : b;
            CMD_TO_INT: r.result = a >>> FRAC_BITS;
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;
    assign pending_count = expected_results.size();

    // Predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin
        t_alu_out want;
        if (i_rst_n && i_valid && !o_stall)
            expected_results.push_back(alu_predict(i_cmd, i_a_operand, i_b_operand));
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_result, 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_result !== want.result)
                    report_mismatch("result", o_result, want.result);
                if (o_compare_flag !== want.compare_flag)
                    report_mismatch("compare_flag", 32'(o_compare_flag),
                                    32'(want.compare_flag));
                if (o_divide_error !== want.divide_error)
                    report_mismatch("divide_error", 32'(o_divide_error),
                                    32'(want.divide_error));
            end
        end
    end
endmodule

FILE: tb/sv/fixed_point_alu_test.sv
module fixed_point_alu_test;
    timeunit 1ns;
    timeprecision 1ps;
    import fpa_pkg::*;

    localparam int NUM_RANDOM = 1350;
    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [3:0]  i_cmd = '0;
    logic [31:0] i_a_operand = '0;
    logic [31:0] i_b_operand = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_result;
    logic        o_compare_flag;
    logic        o_divide_error;
    int          fail_count;
    int          pending_count;
    int          cycle_count = 0;

    fixed_point_alu dut (.*);
    fixed_point_alu_checker checker_inst (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return 32'($signed($urandom_range(0, 2048)) - 1024);
            4: return 32'($urandom_range(0, 65535)) << 8;
            default: return $urandom;
        endcase
    endfunction

    // Offer one item and hold it until the transfer
    task automatic send_item(logic [3:0] cmd, logic [31:0] a, logic [31:0] b, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_a_operand <= a;
        i_b_operand <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Receiver: random stalls, one long hold-off early on
    initial begin
        int wait_cycles;
        @(posedge i_rst_n);
        repeat (60) @(posedge i_clk);
        i_stall <= 1'b1;
        repeat (300) @(posedge i_clk);
        forever begin
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (wait_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Reset, directed items, random items, drain and verdict
    initial begin
        logic [31:0] edge_vals[4];
        logic [3:0]  cmd;
        int          gap;
        edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int c = 0; c < 16; c++)
            send_item(4'(c), edge_vals[c % 4], edge_vals[(c + 1) % 4], 0);
        send_item(CMD_DIV, 32'h0000_0100, 32'h0, 0);
        send_item(CMD_DIV, 32'h8000_0000, 32'hffff_ffff, 0);
        send_item(CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 0);
        send_item(CMD_MAX, 32'h0000_0005, 32'h0000_0005, 0);
        send_item(CMD_TO_INT, 32'hffff_ff01, 32'h0, 0);
        send_item(CMD_EQ, 32'h1234_5678, 32'h1234_5678, 0);
        for (int n = 0; n < NUM_RANDOM; n++) begin
            cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(14, 15))
                                               : 4'($urandom_range(0, 13));
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
            if (n > 600 && n < 700)
                gap = 0;
            send_item(cmd, pick_operand(), ($urandom_range(0, 15) == 0) ? '0 : pick_operand(),
                      gap);
        end
        i_valid <= 1'b0;
        while (pending_count != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
